// ----- src/rvexu_pkg.sv -----
// Shared types and operation codes for the RV32IM execute unit.
package rvexu_pkg;

	localparam logic [3:0] FUNC_LUI    = 4'd0;
	localparam logic [3:0] FUNC_AUIPC  = 4'd1;
	localparam logic [3:0] FUNC_JAL    = 4'd2;
	localparam logic [3:0] FUNC_JALR   = 4'd3;
	localparam logic [3:0] FUNC_BRANCH = 4'd4;
	localparam logic [3:0] FUNC_LOAD   = 4'd5;
	localparam logic [3:0] FUNC_STORE  = 4'd6;
	localparam logic [3:0] FUNC_OP_IMM = 4'd7;
	localparam logic [3:0] FUNC_OP     = 4'd8;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_MUL    = 3'd0;
	localparam logic [2:0] F3_MULHSU = 3'd2;
	localparam logic [2:0] F3_MULHU  = 3'd3;

	localparam logic [6:0] FUNCT7_MUL       = 7'd1;
	localparam logic [6:0] FUNCT7_SHIFT_MSK = 7'h7e;
	localparam logic [31:0] JALR_MASK       = 32'hffff_fffe;
	localparam logic [31:0] LINK_STEP       = 32'd4;

	typedef struct packed {
		logic [3:0]         func;
		logic [2:0]         funct3;
		logic [6:0]         funct7;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
		logic signed [31:0] operand_c;
		logic signed [31:0] immediate;
		logic [5:0]         shift_amount;
		logic [31:0]        pc;
		logic               bubble;
	} exu_in_t;

	typedef struct packed {
		logic [31:0]        result;
		logic [31:0]        target_address;
		logic               write_back_enable;
		logic signed [31:0] store_data;
		logic               bubble_out;
	} exu_out_t;

endpackage

// ----- src/rvexu_mul.sv -----
// Two-stage 33-by-33-bit multiplier for the MUL, MULH, MULHSU and MULHU variants.
module rvexu_mul import rvexu_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [2:0]  funct3,
	output logic [63:0] product
);

	logic        sign_a;
	logic        sign_b;
	logic [32:0] ext_a;
	logic [32:0] ext_b;
	logic [49:0] pp_lo;
	logic [49:0] pp_hi;
	logic [49:0] pp_lo_s2;
	logic [49:0] pp_hi_s2;

	always_comb begin
		sign_a = (funct3 != F3_MULHU);
		sign_b = (funct3 != F3_MULHU) && (funct3 != F3_MULHSU);
		ext_a  = {sign_a & a[31], a};
		ext_b  = {sign_b & b[31], b};
		pp_lo  = 50'($signed(ext_a) * $signed({1'b0, ext_b[15:0]}));
		pp_hi  = 50'($signed(ext_a) * $signed(ext_b[32:16]));
	end

	always_ff @(posedge clk) begin
		pp_lo_s2 <= pp_lo;
		pp_hi_s2 <= pp_hi;
	end

	assign product = 64'($signed(pp_lo_s2)) + (64'($signed(pp_hi_s2)) << 16);

endmodule

// ----- src/rv32im_execute_unit.sv -----
// Top level of the RV32IM execute unit: three-stage pipeline around the ALU and multiplier.
//
// Usage: present one decoded instruction on instr and raise start for one cycle
// per item. busy is held low, so an item may be started in every clock cycle.
// Stage one registers the item. Stage two evaluates the ALU, branch compare,
// target add and the two partial products of the multiply. Stage three adds the
// partial products, picks the multiply word or the ALU value, applies bubble
// squashing and drives the output register.
// Every item gives exactly one result: done is high for one cycle with the
// result on res, once the item has passed all three register stages. Throughput
// is one item per cycle, with the multiply split across stages two and three.
// A squashed item still produces a result with every field zero except
// bubble_out. The receiver cannot hold results off, so a result is present
// exactly in the cycle that done marks it.
// Reset clears all valid bits at once; items in flight are dropped and done
// stays low until new items pass through the pipeline.
module rv32im_execute_unit import rvexu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  exu_in_t  instr,
	output logic     done,
	output exu_out_t res
);

	logic        valid_s1;
	exu_in_t     instr_s1;

	logic        valid_s2;
	logic [31:0] alu_s2;
	logic [31:0] target_s2;
	logic        wb_s2;
	logic [31:0] store_s2;
	logic        bubble_s2;
	logic        is_mul_s2;
	logic        mul_hi_s2;

	logic        valid_s3;
	exu_out_t    out_s3;

	logic [31:0] ua;
	logic [31:0] ub;
	logic [31:0] uc;
	logic [31:0] uimm;
	logic [5:0]  sh;
	logic [31:0] shl_v;
	logic [31:0] srl_v;
	logic [31:0] sra_v;
	logic        lt_s;
	logic        lt_u;
	logic [31:0] alu_v;
	logic [31:0] target_v;
	logic        is_mul;
	logic [63:0] product_v;
	exu_out_t    out_v;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		instr_s1 <= instr;
	end

	rvexu_mul u_mul (
		.clk     (clk),
		.a       (ua),
		.b       (ub),
		.funct3  (instr_s1.funct3),
		.product (product_v)
	);

	always_comb begin
		ua    = instr_s1.operand_a;
		ub    = instr_s1.operand_b;
		uc    = instr_s1.operand_c;
		uimm  = instr_s1.immediate;
		sh    = (instr_s1.func == FUNC_OP) ? ub[5:0] : instr_s1.shift_amount;
		shl_v = sh[5] ? 32'd0 : (ua << sh[4:0]);
		srl_v = sh[5] ? 32'd0 : (ua >> sh[4:0]);
		sra_v = sh[5] ? {32{ua[31]}} : 32'($signed(ua) >>> sh[4:0]);
		lt_s  = $signed(ua) < $signed((instr_s1.func == FUNC_OP_IMM) ? uimm : ub);
		lt_u  = ua < ub;
		is_mul = (instr_s1.func == FUNC_OP) && (instr_s1.funct7 == FUNCT7_MUL);
		alu_v    = 32'd0;
		target_v = 32'd0;
		unique case (instr_s1.func)
			FUNC_LUI: alu_v = ub;
			FUNC_AUIPC: alu_v = instr_s1.pc + ub;
			FUNC_JAL: begin
				alu_v    = instr_s1.pc + LINK_STEP;
				target_v = instr_s1.pc + ub;
			end
			FUNC_JALR: begin
				alu_v    = instr_s1.pc + LINK_STEP;
				target_v = (ua + ub) & JALR_MASK;
			end
			FUNC_BRANCH: begin
				target_v = instr_s1.pc + uc;
				unique case (instr_s1.funct3)
					F3_BEQ:  alu_v = {31'd0, ua == ub};
					F3_BNE:  alu_v = {31'd0, ua != ub};
					F3_BLT:  alu_v = {31'd0, lt_s};
					F3_BGE:  alu_v = {31'd0, !lt_s};
					F3_BLTU: alu_v = {31'd0, lt_u};
					F3_BGEU: alu_v = {31'd0, !lt_u};
					default: alu_v = 32'd0;
				endcase
			end
			FUNC_LOAD, FUNC_STORE: alu_v = ua + uimm;
			FUNC_OP_IMM: begin
				unique case (instr_s1.funct3)
					F3_ADD:  alu_v = ua + uimm;
					F3_SLL:  alu_v = shl_v;
					F3_SLT:  alu_v = {31'd0, lt_s};
					F3_SLTU: alu_v = {31'd0, lt_u};
					F3_XOR:  alu_v = ua ^ uimm;
					F3_SR:   alu_v = ((instr_s1.funct7 & FUNCT7_SHIFT_MSK) == 7'd0) ?
						srl_v : sra_v;
					F3_OR:   alu_v = ua | uimm;
					F3_AND:  alu_v = ua & uimm;
					default: alu_v = 32'd0;
				endcase
			end
			FUNC_OP: begin
				unique case (instr_s1.funct3)
					F3_ADD:  alu_v = (instr_s1.funct7 == 7'd0) ? ua + ub : ua - ub;
					F3_SLL:  alu_v = shl_v;
					F3_SLT:  alu_v = {31'd0, lt_s};
					F3_SLTU: alu_v = {31'd0, lt_u};
					F3_XOR:  alu_v = ua ^ ub;
					F3_OR:   alu_v = ua | ub;
					F3_AND:  alu_v = ua & ub;
					default: alu_v = 32'd0;
				endcase
			end
			default: begin
				alu_v    = 32'd0;
				target_v = 32'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		alu_s2    <= alu_v;
		target_s2 <= target_v;
		wb_s2     <= (instr_s1.func != FUNC_BRANCH) && (instr_s1.func != FUNC_STORE);
		store_s2  <= uc;
		bubble_s2 <= instr_s1.bubble;
		is_mul_s2 <= is_mul;
		mul_hi_s2 <= (instr_s1.funct3 != F3_MUL);
	end

	always_comb begin
		if (bubble_s2) begin
			out_v            = '0;
			out_v.bubble_out = 1'b1;
		end else begin
			out_v.result            = is_mul_s2 ?
				(mul_hi_s2 ? product_v[63:32] : product_v[31:0]) : alu_s2;
			out_v.target_address    = target_s2;
			out_v.write_back_enable = wb_s2;
			out_v.store_data        = store_s2;
			out_v.bubble_out        = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		out_s3 <= out_v;
	end

	assign done = valid_s3;
	assign res  = out_s3;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done)
		else $error("accepted item did not complete after three cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3))
		else $error("result strobe without an accepted item");

	a_bubble_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.bubble_out |-> res.result == 32'd0 && res.target_address == 32'd0
			&& !res.write_back_enable && res.store_data == 32'sd0)
		else $error("squashed item carried nonzero fields");

	a_bubble_track: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.bubble_out == $past(instr.bubble, 3))
		else $error("bubble flag lost in the pipeline");

endmodule
